FILE: hdl/anp_pkg.sv
// Package for the ASCII number text parser: beat structs, parse modes,
// character codes and the per-character state record.
// Depends on nothing; used by anp_step and ascii_number_text_parser.
`default_nettype none

package anp_pkg;

  // One incoming beat: a character and the end-of-text mark.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_beat_t;

  // One outgoing beat: the parsed number.
  typedef struct packed {
    logic        negative;
    logic [63:0] magnitude;
    logic [4:0]  frac_digits;
    logic        hex_form;
    logic        saturated;
  } out_beat_t;

  // Parse modes. The eighth encoding is unused and behaves as finished.
  typedef enum logic [2:0] {
    M_SKIP  = 3'd0,
    M_ZERO  = 3'd1,
    M_INT   = 3'd2,
    M_FRAC  = 3'd3,
    M_FDROP = 3'd4,
    M_HEX   = 3'd5,
    M_DONE  = 3'd6
  } mode_t;

  // Running state carried from one character to the next.
  typedef struct packed {
    mode_t       mode;
    logic [63:0] accum;
    logic [4:0]  frac_count;
    logic        sign_flag;
    logic        hex_flag;
    logic        sat_flag;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    mode:       M_SKIP,
    accum:      64'd0,
    frac_count: 5'd0,
    sign_flag:  1'b0,
    hex_flag:   1'b0,
    sat_flag:   1'b0
  };

  // Character codes of interest.
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

endpackage

`default_nettype wire

FILE: hdl/anp_step.sv
// Next-state logic for one character of the number text.
// Depends on anp_pkg; instanced by ascii_number_text_parser.
`default_nettype none

module anp_step #(
  parameter int MAG_BITS        = 64,
  parameter int MAX_FRAC_DIGITS = 19
) (
  input  wire  anp_pkg::parse_state_t cur,
  input  wire  logic [7:0]            ch,
  output anp_pkg::parse_state_t       nxt
);

  localparam int W = MAG_BITS + 4;

  logic [MAG_BITS-1:0] acc;
  logic [W-1:0]        wide;
  logic [W-1:0]        t10;
  logic [W-1:0]        t16;
  logic                is_dec;
  logic [3:0]          dec_val;
  logic                is_hex;
  logic [3:0]          hex_val;
  logic                ovf10;
  logic                ovf16;

  // Character classification.
  always_comb begin
    is_dec  = (ch >= anp_pkg::CH_ZERO) && (ch <= anp_pkg::CH_NINE);
    dec_val = ch[3:0];
    is_hex  = 1'b1;
    hex_val = ch[3:0];
    if (is_dec) begin
      hex_val = ch[3:0];
    end else if ((ch >= anp_pkg::CH_LA) && (ch <= anp_pkg::CH_LF)) begin
      hex_val = ch[3:0] + 4'd9;
    end else if ((ch >= anp_pkg::CH_UA) && (ch <= anp_pkg::CH_UF)) begin
      hex_val = ch[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Multiply-add candidates; any carry above the magnitude width is overflow.
  assign acc   = cur.accum[MAG_BITS-1:0];
  assign wide  = W'(acc);
  assign t10   = (wide << 3) + (wide << 1) + W'(dec_val);
  assign t16   = (wide << 4) | W'(hex_val);
  assign ovf10 = (t10[W-1:MAG_BITS] != 4'd0);
  assign ovf16 = (t16[W-1:MAG_BITS] != 4'd0);

  // Mode transitions and accumulator update.
  always_comb begin
    logic int_pos;
    int_pos = 1'b0;
    nxt     = cur;
    case (cur.mode)
      anp_pkg::M_SKIP: begin
        if (ch < anp_pkg::CH_BANG) begin
          nxt.mode = anp_pkg::M_SKIP;
        end else if (ch == anp_pkg::CH_ZERO) begin
          nxt.mode = anp_pkg::M_ZERO;
        end else if (ch == anp_pkg::CH_MINUS) begin
          nxt.sign_flag = 1'b1;
          nxt.mode      = anp_pkg::M_INT;
        end else if (ch == anp_pkg::CH_PLUS) begin
          nxt.mode = anp_pkg::M_INT;
        end else begin
          int_pos = 1'b1;
        end
      end
      anp_pkg::M_ZERO: begin
        if (ch == anp_pkg::CH_LX) begin
          nxt.hex_flag = 1'b1;
          nxt.mode     = anp_pkg::M_HEX;
        end else begin
          int_pos = 1'b1;
        end
      end
      anp_pkg::M_INT: begin
        int_pos = 1'b1;
      end
      anp_pkg::M_FRAC: begin
        if (!is_dec) begin
          nxt.mode = anp_pkg::M_DONE;
        end else if (cur.sat_flag || ovf10 ||
                     (32'(cur.frac_count) >= MAX_FRAC_DIGITS)) begin
          nxt.mode = anp_pkg::M_FDROP;
        end else begin
          nxt.accum      = 64'(t10[MAG_BITS-1:0]);
          nxt.frac_count = cur.frac_count + 5'd1;
        end
      end
      anp_pkg::M_FDROP: begin
        if (!is_dec) begin
          nxt.mode = anp_pkg::M_DONE;
        end
      end
      anp_pkg::M_HEX: begin
        if (!is_hex) begin
          nxt.mode = anp_pkg::M_DONE;
        end else if (cur.sat_flag || ovf16) begin
          nxt.accum    = 64'({MAG_BITS{1'b1}});
          nxt.sat_flag = 1'b1;
        end else begin
          nxt.accum = 64'(t16[MAG_BITS-1:0]);
        end
      end
      default: begin
        nxt = cur;
      end
    endcase

    // A character in integer position: digit, point, or end of parsing.
    if (int_pos) begin
      if (is_dec) begin
        nxt.mode = anp_pkg::M_INT;
        if (cur.sat_flag || ovf10) begin
          nxt.accum    = 64'({MAG_BITS{1'b1}});
          nxt.sat_flag = 1'b1;
        end else begin
          nxt.accum = 64'(t10[MAG_BITS-1:0]);
        end
      end else if (ch == anp_pkg::CH_DOT) begin
        nxt.mode = anp_pkg::M_FRAC;
      end else begin
        nxt.mode = anp_pkg::M_DONE;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ascii_number_text_parser.sv
// Top level of the ASCII number text parser: input register, parse state,
// result register. Depends on anp_pkg and anp_step.
//
//   channel  direction  handshake              beat type
//   chr      in         chr_valid / chr_ready  anp_pkg::in_beat_t
//   res      out        res_valid / res_ready  anp_pkg::out_beat_t
//
// One character is taken per cycle unless a last beat waits on a full result
// slot; each passes the input register and is then folded into the parse state,
// and the beat flagged last loads the result register. Reset is synchronous and
// returns the parse state to skipping whitespace. A stalled result register holds
// only beats flagged last; other characters keep flowing past it.
`default_nettype none

module ascii_number_text_parser #(
  parameter int MAG_BITS        = 64,
  parameter int MAX_FRAC_DIGITS = 19
) (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                chr_valid,
  output logic                      chr_ready,
  input  wire  anp_pkg::in_beat_t   chr,
  output logic                      res_valid,
  input  wire  logic                res_ready,
  output anp_pkg::out_beat_t        res
);

  logic                  iv;
  anp_pkg::in_beat_t     ibeat;
  anp_pkg::parse_state_t state;
  anp_pkg::parse_state_t state_next;
  logic                  consume;

  anp_step #(
    .MAG_BITS        (MAG_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_step (
    .cur (state),
    .ch  (ibeat.ch),
    .nxt (state_next)
  );

  // The held character moves on unless it is last and the result slot is full.
  assign consume   = iv && (!ibeat.last || !res_valid || res_ready);
  assign chr_ready = !iv || consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (chr_valid && chr_ready) begin
      iv <= 1'b1;
    end else if (consume) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chr_valid && chr_ready) begin
      ibeat <= chr;
    end
  end

  // Parse state; the last character of a text returns it to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= anp_pkg::STATE_RESET;
    end else if (consume) begin
      state <= ibeat.last ? anp_pkg::STATE_RESET : state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (consume && ibeat.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && ibeat.last) begin
      res.negative    <= state_next.sign_flag;
      res.magnitude   <= state_next.accum;
      res.frac_digits <= state_next.frac_count;
      res.hex_form    <= state_next.hex_flag;
      res.saturated   <= state_next.sat_flag;
    end
  end

endmodule

`default_nettype wire
